// ----- hdl/tbl_pkg.sv -----
// ----------------------------------------------------------------------------
// tbl_pkg
// shared constants, codes and helpers of the typing break lockout block
// ----------------------------------------------------------------------------
package tbl_pkg;

  localparam int unsigned MATRIX_COLUMNS = 16;
  localparam int unsigned LEFT_LAST_COL  = MATRIX_COLUMNS / 2;
  localparam int unsigned MS_PER_SECOND  = 1000;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned COL_W    = 4;
  localparam int unsigned SEC_W    = 16;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned MS_W     = 26;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [SEC_W-1:0] IDLE_SEC_RST    = SEC_W'(300);
  localparam logic [SEC_W-1:0] SESSION_SEC_RST = SEC_W'(2700);
  localparam logic [SEC_W-1:0] LOCK_SEC_RST    = SEC_W'(300);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IDLE_LIMIT    = 3'd0,
    REG_SESSION_LIMIT = 3'd1,
    REG_LOCK_DURATION = 3'd2,
    REG_LEFT_LIMIT    = 3'd3,
    REG_RIGHT_LIMIT   = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    LC_NONE  = 2'd0,
    LC_START = 2'd1,
    LC_END   = 2'd2
  } lock_change_e;

  function automatic logic [MS_W-1:0] sec_to_ms(input logic [SEC_W-1:0] sec);
    logic [31:0] prod;
    prod = 32'(sec) * 32'(MS_PER_SECOND);
    return prod[MS_W-1:0];
  endfunction

endpackage

// ----- hdl/typing_break_lockout.sv -----
// ----------------------------------------------------------------------------
// typing_break_lockout
// key event filter that forces typing breaks by hand count or session time
// ----------------------------------------------------------------------------
//  channel   dir  contents
//  s_axis    in   tdata: now_ms[31:0], key_column[35:32]; tuser: pressed_now
//  m_axis    out  tdata: consumed[0], lock_change[2:1]
//  cfg       in   write enable, register index, 16-bit data
//
//  one event per cycle while m_axis is not stalled; input register, then result register
//  the event sits in an input register, one pass of compare logic updates the
//  session state and loads the result register in the same edge
//  limits in seconds are scaled to milliseconds when written
//  m_axis stall holds the result and stops the input register from advancing
//  reset clears state to unlocked, empty session and default limits
// ----------------------------------------------------------------------------
module typing_break_lockout (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // now_ms[31:0], key_column[35:32], zero fill
  input  logic [tbl_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // pressed_now
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // consumed[0], lock_change[2:1], zero fill
  output logic [tbl_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic [tbl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tbl_pkg::SEC_W-1:0]          cfg_data_i
);

  // configuration
  logic [tbl_pkg::MS_W-1:0]   idle_ms_q, session_ms_q, lock_ms_q;
  logic [tbl_pkg::CNT_W-1:0]  left_lim_q, right_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_ms_q    <= tbl_pkg::sec_to_ms(tbl_pkg::IDLE_SEC_RST);
      session_ms_q <= tbl_pkg::sec_to_ms(tbl_pkg::SESSION_SEC_RST);
      lock_ms_q    <= tbl_pkg::sec_to_ms(tbl_pkg::LOCK_SEC_RST);
      left_lim_q   <= '0;
      right_lim_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tbl_pkg::REG_IDLE_LIMIT:    idle_ms_q    <= tbl_pkg::sec_to_ms(cfg_data_i);
        tbl_pkg::REG_SESSION_LIMIT: session_ms_q <= tbl_pkg::sec_to_ms(cfg_data_i);
        tbl_pkg::REG_LOCK_DURATION: lock_ms_q    <= tbl_pkg::sec_to_ms(cfg_data_i);
        tbl_pkg::REG_LEFT_LIMIT:    left_lim_q   <= cfg_data_i;
        tbl_pkg::REG_RIGHT_LIMIT:   right_lim_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic                         in_vld_q;
  logic [tbl_pkg::TIME_W-1:0]   now_q;
  logic [tbl_pkg::COL_W-1:0]    col_q;
  logic                         press_q;
  logic                         advance;
  logic                         out_vld_q;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      now_q   <= s_axis_tdata[tbl_pkg::TIME_W-1:0];
      col_q   <= s_axis_tdata[tbl_pkg::TIME_W +: tbl_pkg::COL_W];
      press_q <= s_axis_tuser;
    end
  end

  // session state
  logic [tbl_pkg::TIME_W-1:0] lock_start_q, lock_start_d;
  logic [tbl_pkg::TIME_W-1:0] last_press_q, last_press_d;
  logic [tbl_pkg::TIME_W-1:0] sess_start_q, sess_start_d;
  logic [tbl_pkg::CNT_W-1:0]  left_cnt_q, left_cnt_d;
  logic [tbl_pkg::CNT_W-1:0]  right_cnt_q, right_cnt_d;
  logic                       consumed_d, consumed_q;
  tbl_pkg::lock_change_e      change_d, change_q;

  logic [tbl_pkg::TIME_W-1:0] lock_age, idle_age, sess_age, sess_base;
  logic [tbl_pkg::CNT_W-1:0]  left_base, right_base;
  logic locked, hold, expired, idle_gap, restart, hand_hit, sess_hit, is_left;

  always_comb begin
    lock_age   = now_q - lock_start_q;
    idle_age   = now_q - last_press_q;
    locked     = (lock_start_q != '0);
    hold       = locked && (lock_age <= tbl_pkg::TIME_W'(lock_ms_q));
    expired    = locked && !hold;
    idle_gap   = (last_press_q != '0) && (idle_age >= tbl_pkg::TIME_W'(idle_ms_q));
    restart    = expired || idle_gap;
    left_base  = restart ? '0 : left_cnt_q;
    right_base = restart ? '0 : right_cnt_q;
    sess_base  = restart ? now_q : sess_start_q;
    sess_age   = now_q - sess_base;
    hand_hit   = ((left_lim_q != '0) && (left_base >= left_lim_q)) ||
                 ((right_lim_q != '0) && (right_base >= right_lim_q));
    sess_hit   = (session_ms_q != '0) && (sess_age >= tbl_pkg::TIME_W'(session_ms_q));
    is_left    = (32'(col_q) <= 32'(tbl_pkg::LEFT_LAST_COL));

    lock_start_d = lock_start_q;
    last_press_d = last_press_q;
    sess_start_d = sess_start_q;
    left_cnt_d   = left_cnt_q;
    right_cnt_d  = right_cnt_q;
    consumed_d   = 1'b0;
    change_d     = tbl_pkg::LC_NONE;

    if (hold) begin
      consumed_d = 1'b1;
    end else begin
      sess_start_d = sess_base;
      left_cnt_d   = left_base;
      right_cnt_d  = right_base;
      lock_start_d = '0;
      if (expired) begin
        change_d = tbl_pkg::LC_END;
      end
      if (hand_hit) begin
        lock_start_d = now_q;
        change_d     = tbl_pkg::LC_START;
        consumed_d   = 1'b1;
      end else if (sess_hit) begin
        lock_start_d = last_press_q;
        change_d     = tbl_pkg::LC_START;
        consumed_d   = 1'b1;
      end else if (press_q) begin
        last_press_d = now_q;
        if (is_left) begin
          if (left_base != '1) begin
            left_cnt_d = left_base + 1'b1;
          end
        end else begin
          if (right_base != '1) begin
            right_cnt_d = right_base + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_start_q <= '0;
      last_press_q <= '0;
      sess_start_q <= '0;
      left_cnt_q   <= '0;
      right_cnt_q  <= '0;
    end else if (advance) begin
      lock_start_q <= lock_start_d;
      last_press_q <= last_press_d;
      sess_start_q <= sess_start_d;
      left_cnt_q   <= left_cnt_d;
      right_cnt_q  <= right_cnt_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      consumed_q <= consumed_d;
      change_q   <= change_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0, change_q, consumed_q};

endmodule

// ----- tb/sv/tb_typing_break_lockout.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_typing_break_lockout
// self-checking bench for the typing break lockout key event filter
//
// key events are queued by the stimulus process and sent by a clocked driver
// with random gaps; every accepted event goes through a behavioral model of
// the lockout rules (session, idle gap, hand counts, break timing), whose
// verdict is queued and compared field by field with each result transfer
// the run covers directed corner cases, a limit at the counter maximum and
// random phases under random limit settings, with receiver stalls and one
// long receiver hold-off
// ----------------------------------------------------------------------------
module tb_typing_break_lockout;

  localparam int unsigned CLK_PERIOD = 8;

  typedef struct packed {
    logic [tbl_pkg::TIME_W-1:0] stamp;
    logic [tbl_pkg::COL_W-1:0]  col;
    logic                       pressed;
  } key_event_t;

  typedef struct packed {
    logic                  consumed;
    tbl_pkg::lock_change_e change;
  } lock_result_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  // now_ms[31:0], key_column[35:32], zero fill
  logic [tbl_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  // pressed_now
  logic                           s_axis_tuser = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  // consumed[0], lock_change[2:1], zero fill
  logic [tbl_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           cfg_we_i = 1'b0;
  logic [tbl_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [tbl_pkg::SEC_W-1:0]      cfg_data_i = '0;

  typing_break_lockout i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // limit copies and session state of the model
  logic [tbl_pkg::SEC_W-1:0]  lim_idle_s;
  logic [tbl_pkg::SEC_W-1:0]  lim_session_s;
  logic [tbl_pkg::SEC_W-1:0]  lim_lock_s;
  logic [tbl_pkg::CNT_W-1:0]  lim_left;
  logic [tbl_pkg::CNT_W-1:0]  lim_right;
  logic [tbl_pkg::TIME_W-1:0] st_lock_start;
  logic [tbl_pkg::TIME_W-1:0] st_last_press;
  logic [tbl_pkg::TIME_W-1:0] st_session_start;
  logic [tbl_pkg::CNT_W-1:0]  st_left_cnt;
  logic [tbl_pkg::CNT_W-1:0]  st_right_cnt;

  key_event_t   key_event_q[$];
  lock_result_t verdict_q[$];
  int unsigned  err_cnt = 0;
  int unsigned  send_gap = 0;
  int unsigned  rx_gap = 0;
  logic         rx_hold = 1'b0;
  bit           squeeze_go = 1'b0;

  function automatic void restart_session(logic [tbl_pkg::TIME_W-1:0] stamp);
    st_lock_start    = '0;
    st_left_cnt      = '0;
    st_right_cnt     = '0;
    st_session_start = stamp;
  endfunction

  function automatic lock_result_t break_rule_step(key_event_t ev);
    logic [tbl_pkg::TIME_W-1:0] lock_ms;
    logic [tbl_pkg::TIME_W-1:0] idle_ms;
    logic [tbl_pkg::TIME_W-1:0] session_ms;
    logic [tbl_pkg::TIME_W-1:0] since;
    lock_result_t               res;
    logic                       handled;
    lock_ms     = tbl_pkg::TIME_W'(lim_lock_s) * tbl_pkg::TIME_W'(tbl_pkg::MS_PER_SECOND);
    idle_ms     = tbl_pkg::TIME_W'(lim_idle_s) * tbl_pkg::TIME_W'(tbl_pkg::MS_PER_SECOND);
    session_ms  = tbl_pkg::TIME_W'(lim_session_s) * tbl_pkg::TIME_W'(tbl_pkg::MS_PER_SECOND);
    res.consumed = 1'b0;
    res.change   = tbl_pkg::LC_NONE;
    handled      = 1'b0;
    if (st_lock_start != '0) begin
      since = ev.stamp - st_lock_start;
      if (since <= lock_ms) begin
        res.consumed = 1'b1;
        handled      = 1'b1;
      end else begin
        restart_session(ev.stamp);
        res.change = tbl_pkg::LC_END;
      end
    end
    if (!handled) begin
      since = ev.stamp - st_last_press;
      if (st_last_press != '0 && since >= idle_ms) begin
        restart_session(ev.stamp);
      end
      since = ev.stamp - st_session_start;
      if ((lim_left != '0 && st_left_cnt >= lim_left) ||
          (lim_right != '0 && st_right_cnt >= lim_right)) begin
        st_lock_start = ev.stamp;
        res.change    = tbl_pkg::LC_START;
        res.consumed  = 1'b1;
      end else if (session_ms != '0 && since >= session_ms) begin
        // break dated from the last counted press
        st_lock_start = st_last_press;
        res.change    = tbl_pkg::LC_START;
        res.consumed  = 1'b1;
      end else if (ev.pressed) begin
        if (ev.col <= tbl_pkg::LEFT_LAST_COL) begin
          if (st_left_cnt != '1) st_left_cnt = st_left_cnt + 1'b1;
        end else begin
          if (st_right_cnt != '1) st_right_cnt = st_right_cnt + 1'b1;
        end
        st_last_press = ev.stamp;
      end
    end
    return res;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 57) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    key_event_t nxt;
    key_event_t cur;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        cur.stamp   = s_axis_tdata[31:0];
        cur.col     = s_axis_tdata[35:32];
        cur.pressed = s_axis_tuser;
        verdict_q.push_back(break_rule_step(cur));
      end
      if (send_gap != 0) begin
        send_gap      <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (key_event_q.size() != 0) begin
        nxt = key_event_q.pop_front();
        s_axis_tdata  <= {4'b0000, nxt.col, nxt.stamp};
        s_axis_tuser  <= nxt.pressed;
        s_axis_tvalid <= 1'b1;
        send_gap      <= pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    lock_result_t want;
    lock_result_t got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_gap        <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.consumed = m_axis_tdata[0];
        got.change   = tbl_pkg::lock_change_e'(m_axis_tdata[2:1]);
        if (verdict_q.size() == 0) begin
          if (err_cnt < 10) $display("%0t: result transfer with none pending, tdata %b",
                                     $time, m_axis_tdata);
          err_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (got.consumed !== want.consumed || got.change !== want.change) begin
            if (err_cnt < 10) begin
              $display("%0t: mismatch consumed exp %0d got %0d, lock_change exp %0d got %0d",
                       $time, want.consumed, got.consumed, want.change, got.change);
            end
            err_cnt++;
          end
        end
      end
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap        <= rx_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        rx_gap        <= pick_gap();
      end
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (squeeze_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (150) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #100_000_000;
    $display("tb_typing_break_lockout: done, errors");
    $finish;
  end

  task automatic push_event(logic [tbl_pkg::TIME_W-1:0] stamp,
                            logic [tbl_pkg::COL_W-1:0] col, logic pressed);
    key_event_t ev;
    ev.stamp   = stamp;
    ev.col     = col;
    ev.pressed = pressed;
    key_event_q.push_back(ev);
  endtask

  task automatic put_reg(tbl_pkg::cfg_reg_e idx, logic [tbl_pkg::SEC_W-1:0] val);
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      tbl_pkg::REG_IDLE_LIMIT:    lim_idle_s    = val;
      tbl_pkg::REG_SESSION_LIMIT: lim_session_s = val;
      tbl_pkg::REG_LOCK_DURATION: lim_lock_s    = val;
      tbl_pkg::REG_LEFT_LIMIT:    lim_left      = val;
      tbl_pkg::REG_RIGHT_LIMIT:   lim_right     = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic program_limits(logic [tbl_pkg::SEC_W-1:0] idle,
                                logic [tbl_pkg::SEC_W-1:0] session,
                                logic [tbl_pkg::SEC_W-1:0] lock,
                                logic [tbl_pkg::CNT_W-1:0] left,
                                logic [tbl_pkg::CNT_W-1:0] right);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    put_reg(tbl_pkg::REG_IDLE_LIMIT, idle);
    put_reg(tbl_pkg::REG_SESSION_LIMIT, session);
    put_reg(tbl_pkg::REG_LOCK_DURATION, lock);
    put_reg(tbl_pkg::REG_LEFT_LIMIT, left);
    put_reg(tbl_pkg::REG_RIGHT_LIMIT, right);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every queued event has been sent and answered
  task automatic drain();
    @(negedge clk_i);
    while (key_event_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [tbl_pkg::SEC_W-1:0] pick_limit(int unsigned lo, int unsigned hi);
    if ($urandom_range(0, 99) < 15) return tbl_pkg::SEC_W'($urandom_range(0, 65535));
    return tbl_pkg::SEC_W'($urandom_range(lo, hi));
  endfunction

  task automatic random_phase(int unsigned n);
    logic [tbl_pkg::TIME_W-1:0] t;
    int unsigned                r;
    program_limits(pick_limit(1, 8), pick_limit(0, 8), pick_limit(0, 4),
                   pick_limit(0, 12), pick_limit(0, 12));
    t = $urandom();
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) t = $urandom();
      else if (r < 15) t = t + $urandom_range(0, 20000);
      else t = t + $urandom_range(0, 1500);
      push_event(t, tbl_pkg::COL_W'($urandom_range(0, 15)), $urandom_range(0, 9) < 8);
    end
  endtask

  initial begin
    lim_idle_s       = tbl_pkg::IDLE_SEC_RST;
    lim_session_s    = tbl_pkg::SESSION_SEC_RST;
    lim_lock_s       = tbl_pkg::LOCK_SEC_RST;
    lim_left         = '0;
    lim_right        = '0;
    st_lock_start    = '0;
    st_last_press    = '0;
    st_session_start = '0;
    st_left_cnt      = '0;
    st_right_cnt     = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // hand limits, lock boundary, wrap of time and a break starting at zero
    program_limits(5, 0, 1, 3, 2);
    push_event(32'd0, 4'd0, 1'b1);
    push_event(32'd0, 4'd15, 1'b0);
    push_event(32'd100, 4'd8, 1'b1);
    push_event(32'd200, 4'd9, 1'b1);
    push_event(32'd300, 4'd15, 1'b1);
    push_event(32'd400, 4'd3, 1'b0);
    push_event(32'd900, 4'd3, 1'b1);
    push_event(32'd1400, 4'd3, 1'b1);
    push_event(32'd1401, 4'd3, 1'b1);
    push_event(32'hFFFF_FFFD, 4'd1, 1'b1);
    push_event(32'hFFFF_FFFE, 4'd2, 1'b1);
    push_event(32'hFFFF_FFFF, 4'd5, 1'b1);
    push_event(32'd0, 4'd4, 1'b0);
    push_event(32'd1, 4'd4, 1'b1);
    drain();

    // session limit break dated from the last press
    program_limits(10, 2, 3, 0, 0);
    push_event(32'd100000, 4'd1, 1'b1);
    push_event(32'd101500, 4'd12, 1'b1);
    push_event(32'd102000, 4'd12, 1'b0);
    push_event(32'd104500, 4'd12, 1'b0);
    push_event(32'd104501, 4'd12, 1'b1);
    drain();

    // zero limits: every event starts a new session
    program_limits(0, 0, 0, 0, 0);
    push_event(32'd200000, 4'd5, 1'b1);
    push_event(32'd200000, 4'd13, 1'b1);
    push_event(32'd200400, 4'd2, 1'b0);
    drain();

    // largest limits
    program_limits('1, '1, '1, '1, '1);
    push_event(32'd300000, 4'd0, 1'b1);
    push_event(32'd300001, 4'd15, 1'b1);
    push_event(32'd65735400, 4'd7, 1'b0);
    push_event(32'd65835001, 4'd7, 1'b1);
    push_event(32'd65835002, 4'd7, 1'b1);
    drain();

    // a limit at the counter maximum
    program_limits('1, 0, 0, '1, 0);
    push_event(32'd70000, 4'd0, 1'b1);
    push_event(32'd70000, 4'd10, 1'b1);
    push_event(32'd70001, 4'd10, 1'b1);
    drain();

    for (int unsigned p = 0; p < 7; p++) begin
      random_phase(120);
      if (p == 0) squeeze_go = 1'b1;
      drain();
    end

    repeat (10) @(negedge clk_i);
    if (verdict_q.size() != 0) err_cnt += verdict_q.size();
    if (err_cnt == 0) begin
      $display("tb_typing_break_lockout: done, clean");
    end else begin
      $display("tb_typing_break_lockout: done, errors");
    end
    $finish;
  end

endmodule
